### sv/cdll_pkg.sv
package cdll_pkg;

   localparam int unsigned FUNC_W   = 3;
   localparam int unsigned POS_W    = 6;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned COUNT_W  = 7;

   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_FRONT = 3'd0,
      FN_PUSH_BACK  = 3'd1,
      FN_POP_AT     = 3'd2,
      FN_INSERT_AT  = 3'd3,
      FN_TRAV_FWD   = 3'd4,
      FN_TRAV_BWD   = 3'd5
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

endpackage

### sv/cdll_if.sv
interface cdll_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [cdll_pkg::FUNC_W-1:0]            func;
   logic [cdll_pkg::POS_W-1:0]             position;
   logic signed [cdll_pkg::VALUE_W-1:0]    value;
   modport source (output valid, func, position, value, input ready);
   modport sink   (input valid, func, position, value, output ready);
endinterface

interface cdll_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [cdll_pkg::VALUE_W-1:0]    item_value;
   logic [cdll_pkg::STATUS_W-1:0]          status;
   logic [cdll_pkg::COUNT_W-1:0]           entry_count;
   logic                                   last;
   modport source (output valid, item_value, status, entry_count, last, input ready);
   modport sink   (input valid, item_value, status, entry_count, last, output ready);
endinterface

### sv/cdll_ram.sv
module cdll_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### sv/circular_doubly_linked_list_engine_core.sv
// Circular doubly linked list engine.
// req channel: func/position/value. rsp channel: item_value/status/entry_count/last.
// One request is worked at a time; req_ready is high only in the idle state.
// Node store: one synchronous RAM per field (value, next, prev), registered read.
// Add: walk (p next links for insert at position p, none for a push), look, link1
// (skipped on an empty list), new, result. Pop at p: walk p next links, look,
// link2 (skipped for the last entry), result. Error results go straight to result.
// Traversal: forward reads the head; backward first reads one prev link to reach
// the tail. Each item is then read, then shown on the output register, and the
// next read starts once it is taken.
// Each result sits in the output register until taken; a stalled receiver
// simply holds the engine in its emit state, nothing is lost.
// Reset (synchronous, active high) empties the list: all slots free, head 0,
// count 0. RAM contents are not cleared; only linked slots' contents are ever used.
// Every request except a non-empty traversal gives exactly one result with
// last set. The lowest free slot is allocated on an add.
module circular_doubly_linked_list_engine_core #(
   parameter int unsigned CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   cdll_req_if.sink   req,
   cdll_rsp_if.source rsp
);
   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_WALK   = 9'b000000010,  // walk next links toward target (backward traversal: prev link to tail)
      S_LOOK   = 9'b000000100,  // target read: fetch its prev/next
      S_LINK1  = 9'b000001000,  // write first link
      S_LINK2  = 9'b000010000,  // write second link
      S_TREAD  = 9'b000100000,  // traversal read issued
      S_TEMIT  = 9'b001000000,  // traversal item shown
      S_RESP   = 9'b010000000,  // single result shown
      S_NEW    = 9'b100000000   // write new node fields
   } state_type;

   state_type state_ff, state_in;
   logic [CAPACITY-1:0] free_ff, free_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [cdll_pkg::FUNC_W-1:0] func_ff, func_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic [AW-1:0] cur_ff, cur_in, slot_ff, slot_in, nb_ff, nb_in;
   logic [cdll_pkg::VALUE_W-1:0] val_ff, val_in;
   logic is_pop_ff, is_pop_in, front_ff, front_in;
   logic [cdll_pkg::VALUE_W-1:0] oval_ff, oval_in;
   logic [cdll_pkg::STATUS_W-1:0] ost_ff, ost_in;
   logic olast_ff, olast_in;

   // RAM ports
   logic          v_we, n_we, p_we;
   logic [AW-1:0] v_wa, n_wa, p_wa, v_ra, n_ra, p_ra;
   logic [cdll_pkg::VALUE_W-1:0] v_wd, v_rd;
   logic [AW-1:0] n_wd, p_wd, n_rd, p_rd;

   cdll_ram #(.WIDTH(cdll_pkg::VALUE_W), .DEPTH(CAPACITY)) u_val (
      .clock, .wr_en(v_we), .wr_addr(v_wa), .wr_data(v_wd), .rd_addr(v_ra), .rd_data(v_rd));
   cdll_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_next (
      .clock, .wr_en(n_we), .wr_addr(n_wa), .wr_data(n_wd), .rd_addr(n_ra), .rd_data(n_rd));
   cdll_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_prev (
      .clock, .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd), .rd_addr(p_ra), .rd_data(p_rd));

   // lowest free slot
   logic [AW-1:0] low_free;
   always_comb begin
      low_free = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            low_free = AW'(i);
         end
      end
   end

   logic [CW-1:0] req_pos;
   logic pos_big;
   assign pos_big = ({1'b0, req.position} >= (cdll_pkg::POS_W + 1)'(count_ff));
   assign req_pos = CW'(req.position);

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = (state_ff == S_RESP) || (state_ff == S_TEMIT);
   assign rsp.item_value  = oval_ff;
   assign rsp.status      = ost_ff;
   assign rsp.entry_count = cdll_pkg::COUNT_W'(count_ff);
   assign rsp.last        = olast_ff;

   always_comb begin
      state_in = state_ff;
      free_in = free_ff; head_in = head_ff; count_in = count_ff;
      func_in = func_ff; steps_in = steps_ff; cur_in = cur_ff; slot_in = slot_ff;
      nb_in = nb_ff; val_in = val_ff; is_pop_in = is_pop_ff; front_in = front_ff;
      oval_in = oval_ff; ost_in = ost_ff; olast_in = olast_ff;
      v_we = 1'b0; n_we = 1'b0; p_we = 1'b0;
      v_wa = slot_ff; n_wa = slot_ff; p_wa = slot_ff;
      v_wd = val_ff; n_wd = cur_ff; p_wd = nb_ff;
      v_ra = cur_ff; n_ra = cur_ff; p_ra = cur_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               func_in = req.func;
               val_in = req.value;
               cur_in = head_ff;
               n_ra = head_ff; p_ra = head_ff; v_ra = head_ff;
               oval_in = '0; olast_in = 1'b1; ost_in = cdll_pkg::ST_DONE;
               is_pop_in = 1'b0; front_in = 1'b0; steps_in = '0;
               slot_in = low_free;
               priority case (req.func)
                  cdll_pkg::FN_PUSH_FRONT, cdll_pkg::FN_PUSH_BACK,
                  cdll_pkg::FN_INSERT_AT: begin
                     front_in = (req.func == cdll_pkg::FN_PUSH_FRONT) ||
                                (req.func == cdll_pkg::FN_INSERT_AT && !pos_big &&
                                 req.position == '0);
                     if (count_ff == CW'(CAPACITY)) begin
                        ost_in = cdll_pkg::ST_FULL;
                        state_in = S_RESP;
                     end else begin
                        if (req.func == cdll_pkg::FN_INSERT_AT && !pos_big)
                           steps_in = req_pos;
                        state_in = S_WALK;
                     end
                  end
                  cdll_pkg::FN_POP_AT: begin
                     is_pop_in = 1'b1;
                     if (count_ff == '0) begin
                        ost_in = cdll_pkg::ST_EMPTY; state_in = S_RESP;
                     end else if (pos_big) begin
                        ost_in = cdll_pkg::ST_RANGE; state_in = S_RESP;
                     end else begin
                        steps_in = req_pos; state_in = S_WALK;
                     end
                  end
                  cdll_pkg::FN_TRAV_FWD, cdll_pkg::FN_TRAV_BWD: begin
                     if (count_ff == '0) begin
                        ost_in = cdll_pkg::ST_EMPTY; state_in = S_RESP;
                     end else begin
                        steps_in = count_ff;
                        state_in = (req.func == cdll_pkg::FN_TRAV_FWD) ? S_TREAD : S_WALK;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_WALK: begin
            // n_rd/p_rd hold links of cur_ff
            if (func_ff == cdll_pkg::FN_TRAV_BWD) begin
               cur_in = p_rd; v_ra = p_rd; n_ra = p_rd; p_ra = p_rd;
               state_in = S_TREAD;
            end else if (steps_ff != '0) begin
               cur_in = n_rd; n_ra = n_rd; p_ra = n_rd; v_ra = n_rd;
               steps_in = steps_ff - 1'b1;
            end else begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            // cur_ff is target; p_rd its prev, n_rd its next
            if (is_pop_ff) begin
               if (count_ff == CW'(1)) begin
                  head_in = '0;
                  free_in[cur_ff] = 1'b1; count_in = count_ff - 1'b1;
                  state_in = S_RESP;
               end else begin
                  slot_in = p_rd; nb_in = n_rd;
                  n_we = 1'b1; n_wa = p_rd; n_wd = n_rd;
                  if (cur_ff == head_ff) head_in = n_rd;
                  free_in[cur_ff] = 1'b1; count_in = count_ff - 1'b1;
                  state_in = S_LINK2;
               end
            end else if (count_ff == '0) begin
               n_we = 1'b1; n_wa = slot_ff; n_wd = slot_ff;
               p_we = 1'b1; p_wa = slot_ff; p_wd = slot_ff;
               head_in = slot_ff;
               state_in = S_NEW;
            end else begin
               // link slot before cur: prev p = p_rd
               nb_in = p_rd;
               n_we = 1'b1; n_wa = slot_ff; n_wd = cur_ff;
               p_we = 1'b1; p_wa = slot_ff; p_wd = p_rd;
               if (front_ff) head_in = slot_ff;
               state_in = S_LINK1;
            end
         end
         S_LINK1: begin
            n_we = 1'b1; n_wa = nb_ff; n_wd = slot_ff;
            p_we = 1'b1; p_wa = cur_ff; p_wd = slot_ff;
            state_in = S_NEW;
         end
         S_NEW: begin
            v_we = 1'b1; v_wa = slot_ff; v_wd = val_ff;
            free_in[slot_ff] = 1'b0; count_in = count_ff + 1'b1;
            state_in = S_RESP;
         end
         S_LINK2: begin
            p_we = 1'b1; p_wa = nb_ff; p_wd = slot_ff;
            state_in = S_RESP;
         end
         S_TREAD: begin
            // RAM outputs are for cur_ff
            oval_in = v_rd; ost_in = cdll_pkg::ST_DONE;
            olast_in = (steps_ff == CW'(1));
            cur_in = (func_ff == cdll_pkg::FN_TRAV_FWD) ? n_rd : p_rd;
            steps_in = steps_ff - 1'b1;
            state_in = S_TEMIT;
         end
         S_TEMIT: begin
            v_ra = cur_ff; n_ra = cur_ff; p_ra = cur_ff;
            if (rsp.ready) begin
               state_in = olast_ff ? S_IDLE : S_TREAD;
            end
         end
         S_RESP: begin
            v_ra = cur_ff;
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_ff  <= '1;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         free_ff  <= free_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      func_ff <= func_in; steps_ff <= steps_in; cur_ff <= cur_in; slot_ff <= slot_in;
      nb_ff <= nb_in; val_ff <= val_in; is_pop_ff <= is_pop_in; front_ff <= front_in;
      oval_ff <= oval_in; ost_ff <= ost_in; olast_ff <= olast_in;
   end
endmodule

### sv/cdll_checker.sv
module cdll_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [6:0]  rsp_entry_count,
   input logic        rsp_last,
   input logic [31:0] rsp_item_value
);
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken during result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item_value))
      else $error("result dropped under stall");
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != cdll_pkg::ST_DONE |-> rsp_last && rsp_item_value == '0)
      else $error("error result not final");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cdll_pkg::ST_EMPTY |-> rsp_entry_count == '0)
      else $error("empty status with entries");
endmodule

bind circular_doubly_linked_list_engine_core cdll_checker u_cdll_checker (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_entry_count(rsp.entry_count),
   .rsp_last(rsp.last), .rsp_item_value(rsp.item_value)
);
